// ===== sv/ppgl_pkg.sv =====
`timescale 1ns / 1ps

package ppgl_pkg;

    // Number of logical GPIO lines
    localparam int unsigned NUM_LINES = 17;

    // Line groups, one bit per logical line
    localparam logic [16:0] LINES_DATA      = 17'h000FF;
    localparam logic [16:0] LINES_CTL_INV   = 17'h00300;
    localparam logic [16:0] LINES_CTL_PLAIN = 17'h00C00;
    localparam logic [16:0] LINES_WRITABLE  = LINES_DATA | LINES_CTL_INV | LINES_CTL_PLAIN;

    // Line numbers of the group boundaries and of the status lines
    localparam logic [4:0] LINE_DATA_LAST  = 5'd7;
    localparam logic [4:0] LINE_CTL_INV_LO = 5'd8;
    localparam logic [4:0] LINE_CTL_INV_HI = 5'd9;
    localparam logic [4:0] LINE_CTL_PL_LO  = 5'd10;
    localparam logic [4:0] LINE_CTL_PL_HI  = 5'd11;
    localparam logic [4:0] LINE_SELECT_N   = 5'd12;
    localparam logic [4:0] LINE_PAPER      = 5'd13;
    localparam logic [4:0] LINE_ACK        = 5'd14;
    localparam logic [4:0] LINE_BUSY_N     = 5'd15;
    localparam logic [4:0] LINE_ERROR      = 5'd16;

    // Status byte bit positions
    localparam int unsigned STATUS_ERR_BIT = 3;
    localparam int unsigned STATUS_ACK_BIT = 6;

    // Operation codes
    typedef enum logic [2:0] {
        OP_SET_LINE  = 3'd0,
        OP_GET_LINE  = 3'd1,
        OP_MASK_HIGH = 3'd2,
        OP_MASK_LOW  = 3'd3,
        OP_SERVICE   = 3'd4
    } op_t;

    // Configuration register indexes
    localparam logic CFG_DATA_INPUT_MODE = 1'b0;
    localparam logic CFG_ACK_IRQ_ENABLE  = 1'b1;

    // One input transaction
    typedef struct packed {
        logic [7:0]  status_byte;
        logic [7:0]  data_pins_in;
        logic        level;
        logic [16:0] sel_mask;
        logic [4:0]  line_index;
        logic [2:0]  operation;
    } item_t;

    // One result transaction
    typedef struct packed {
        logic       irq_request;
        logic       line_invalid;
        logic       line_level;
        logic [3:0] control_bits_out;
        logic       data_drive_enable;
        logic [7:0] data_pins_out;
    } result_t;

    // Port state carried from item to item
    typedef struct packed {
        logic [7:0] data_latch;
        logic [3:0] control_latch;
        logic       previous_ack;
        logic       irq_pending;
    } port_state_t;

    // Configuration seen by the execution logic
    typedef struct packed {
        logic data_input_mode;
        logic ack_irq_enable;
    } cfg_t;

endpackage

// ===== sv/ppgl_exec.sv =====
`timescale 1ns / 1ps

module ppgl_exec
(
    input  ppgl_pkg::item_t       item,
    input  ppgl_pkg::port_state_t state_cur,
    input  ppgl_pkg::cfg_t        cfg,
    output ppgl_pkg::port_state_t state_next,
    output ppgl_pkg::result_t     result
);
    import ppgl_pkg::*;

    logic        ack;
    logic        pend;
    logic [16:0] line_bit;
    logic [16:0] drv_mask;
    logic        drv_hi;
    logic        drv_en;
    logic [3:0]  ctl_set;
    logic [3:0]  ctl_clr;
    logic [7:0]  data_src;
    logic        get_level;
    logic        get_invalid;
    logic        lvl_out;
    logic        inv_out;

    // ACK edge detection happens before the operation
    assign ack  = item.status_byte[STATUS_ACK_BIT];
    assign pend = state_cur.irq_pending
                  | (ack & ~state_cur.previous_ack & cfg.ack_irq_enable);

    // One-hot of the addressed line; empty for unmapped lines
    assign line_bit = (item.line_index < 5'(NUM_LINES))
                      ? (17'd1 << item.line_index) : 17'd0;

    // Source of a data line read
    assign data_src = cfg.data_input_mode ? item.data_pins_in : state_cur.data_latch;

    // Level of the addressed line for a get
    always_comb
    begin
        get_level   = 1'b0;
        get_invalid = 1'b0;
        case (item.line_index) inside
            [5'd0:LINE_DATA_LAST]:
                get_level = data_src[item.line_index[2:0]];
            LINE_CTL_INV_LO, LINE_CTL_INV_HI:
                get_level = ~state_cur.control_latch[item.line_index[1:0]];
            LINE_CTL_PL_LO, LINE_CTL_PL_HI:
                get_level = state_cur.control_latch[item.line_index[1:0]];
            LINE_PAPER, LINE_ACK:
                get_level = item.status_byte[item.line_index[2:0]];
            LINE_SELECT_N, LINE_BUSY_N:
                get_level = ~item.status_byte[item.line_index[2:0]];
            LINE_ERROR:
                get_level = item.status_byte[STATUS_ERR_BIT];
            default:
                get_invalid = 1'b1;
        endcase
    end

    // Operation decode: drive mask, direction, result level
    always_comb
    begin
        drv_mask = item.sel_mask;
        drv_hi   = 1'b0;
        drv_en   = 1'b0;
        lvl_out  = 1'b0;
        inv_out  = 1'b0;
        case (op_t'(item.operation))
            OP_SET_LINE:
            begin
                drv_mask = line_bit & LINES_WRITABLE;
                drv_hi   = item.level;
                drv_en   = 1'b1;
            end
            OP_GET_LINE:
            begin
                lvl_out = get_level;
                inv_out = get_invalid;
            end
            OP_MASK_HIGH:
            begin
                drv_hi = 1'b1;
                drv_en = 1'b1;
            end
            OP_MASK_LOW:
            begin
                drv_en = 1'b1;
            end
            OP_SERVICE:
            begin
                lvl_out = pend;
            end
            default:
            begin
                drv_en = 1'b0;
            end
        endcase
    end

    // Raw control bits: plain lines follow the level, inverted lines the opposite
    assign ctl_set = drv_hi ? {drv_mask[11:10], 2'b00} : {2'b00, drv_mask[9:8]};
    assign ctl_clr = drv_hi ? {2'b00, drv_mask[9:8]} : {drv_mask[11:10], 2'b00};

    // Next state
    always_comb
    begin
        state_next = state_cur;
        state_next.previous_ack = ack;
        state_next.irq_pending  = pend;
        if (drv_en)
        begin
            state_next.data_latch = drv_hi ? (state_cur.data_latch | drv_mask[7:0])
                                           : (state_cur.data_latch & ~drv_mask[7:0]);
            state_next.control_latch = (state_cur.control_latch & ~ctl_clr) | ctl_set;
        end
        if (op_t'(item.operation) == OP_SERVICE)
        begin
            state_next.irq_pending = 1'b0;
        end
    end

    // Result fields
    always_comb
    begin
        result.data_pins_out     = state_next.data_latch;
        result.data_drive_enable = ~cfg.data_input_mode;
        result.control_bits_out  = state_next.control_latch;
        result.line_level        = lvl_out;
        result.line_invalid      = inv_out;
        result.irq_request       = state_next.irq_pending;
    end

endmodule

// ===== sv/parallel_port_gpio_lines.sv =====
`timescale 1ns / 1ps

// Parallel port GPIO line map: 17 logical lines over data latch, control
// latch and status byte.
// Input stream (s_axis_*): one transaction per operation, carrying the
// operation, line number, mask, level and the sampled data pins and status.
// Output stream (m_axis_*): exactly one result transaction per input, with the
// latch values after the operation, the read level and the interrupt request.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index
// (0 data input mode, 1 ACK interrupt enable; writing 0 to the enable also
// drops a pending interrupt). Write only while no transaction is in flight.
// Path: the accepted input is captured in the input register, and its result
// is then captured in the result register. Throughput: one transaction per
// cycle while the receiver is ready, set by the single execution stage that
// updates the port state.
// Reset clears both latches, the ACK history, the pending interrupt and the
// configuration. When the receiver stalls, the result register holds, the
// input register fills, and s_axis_tready drops once both are occupied.
module parallel_port_gpio_lines
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata, low bit up: operation[2:0], line_index[4:0], sel_mask[16:0],
    // level, data_pins_in[7:0], status_byte[7:0], zero pad[5:0]
    input  logic [47:0] s_axis_tdata,
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata, low bit up: data_pins_out[7:0], data_drive_enable,
    // control_bits_out[3:0], line_level, line_invalid, irq_request
    output logic [15:0] m_axis_tdata,
    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic        cfg_data
);
    import ppgl_pkg::*;

    item_t       in_reg;
    logic        in_valid_reg;
    result_t     out_reg;
    logic        out_valid_reg;
    port_state_t state_reg;
    port_state_t state_next;
    cfg_t        cfg_reg;
    result_t     result;
    logic        exec_en;

    // Execute when an item is held and the result register is free or draining
    assign exec_en       = in_valid_reg & (~out_valid_reg | m_axis_tready);
    assign s_axis_tready = ~in_valid_reg | exec_en;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_reg <= item_t'(s_axis_tdata[41:0]);
        end
    end

    // Operation logic
    ppgl_exec u_exec
    (
        .item       (in_reg),
        .state_cur  (state_reg),
        .cfg        (cfg_reg),
        .state_next (state_next),
        .result     (result)
    );

    // Port state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            cfg_reg   <= '0;
        end
        else
        begin
            if (exec_en)
            begin
                state_reg <= state_next;
            end
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_DATA_INPUT_MODE:
                    begin
                        cfg_reg.data_input_mode <= cfg_data;
                    end
                    CFG_ACK_IRQ_ENABLE:
                    begin
                        cfg_reg.ack_irq_enable <= cfg_data;
                        if (!cfg_data)
                        begin
                            state_reg.irq_pending <= 1'b0;
                        end
                    end
                    default:
                    begin
                        cfg_reg <= cfg_reg;
                    end
                endcase
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (exec_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_en)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    import ppgl_pkg::*;

    // Opcodes left unassigned by the block
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int SETTLE_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int REPORT_LIMIT    = 10;

    // One directed stimulus step: either a register write or a transaction
    typedef struct packed {
        logic    is_cfg;
        logic    cfg_idx;
        logic    cfg_val;
        logic    fixed;
        result_t res;
        item_t   it;
    } plan_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic        cfg_data;

    // Hand-written expectation travelling with the current transaction
    logic        lit_valid;
    result_t     lit_res;

    // Predictor copy of the port
    logic [7:0]  model_latch;
    logic [3:0]  port_ctl;
    logic        ack_seen;
    logic        irq_flag;
    logic        input_mode;
    logic        irq_enable;

    result_t     port_results_q[$];
    plan_row_t   plan_q[$];
    item_t       acc_item;
    result_t     got_res;
    result_t     want_res;

    bit          tx_gaps_on;
    bit          rx_stalls_on;
    int          mismatch_count;
    int          items_sent;
    int          directed_items;
    int          cfg_writes;
    int          irq_serviced;
    int          unmapped_reads;
    int          quiet_cycles;

    parallel_port_gpio_lines u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Drive lines high: plain control bits set, inverted control bits cleared
    function automatic void raise_lines(logic [16:0] m);
        logic [3:0] plain;
        logic [3:0] inv;
        plain       = {m[11:10], 2'b00};
        inv         = {2'b00, m[9:8]};
        model_latch = model_latch | m[7:0];
        port_ctl    = (port_ctl | plain) & ~inv;
    endfunction

    // Drive lines low: plain control bits cleared, inverted control bits set
    function automatic void lower_lines(logic [16:0] m);
        logic [3:0] plain;
        logic [3:0] inv;
        plain       = {m[11:10], 2'b00};
        inv         = {2'b00, m[9:8]};
        model_latch = model_latch & ~m[7:0];
        port_ctl    = (port_ctl & ~plain) | inv;
    endfunction

    // Port behavior for one transaction; updates the predictor state
    function automatic result_t predict_port(item_t it);
        result_t     r;
        logic [31:0] sel;
        logic [4:0]  idx;
        logic [7:0]  src;
        logic        ack;
        logic        lvl;
        logic        bad;
        idx = it.line_index;
        sel = 32'd1 << idx;
        lvl = 1'b0;
        bad = 1'b0;

        // ACK edge detection comes ahead of the operation
        ack = it.status_byte[STATUS_ACK_BIT];
        if (ack && !ack_seen && irq_enable)
            irq_flag = 1'b1;
        ack_seen = ack;

        case (it.operation)
            OP_SET_LINE:
            begin
                if ((sel[16:0] & LINES_WRITABLE) != 17'd0)
                begin
                    if (it.level)
                        raise_lines(sel[16:0]);
                    else
                        lower_lines(sel[16:0]);
                end
            end
            OP_GET_LINE:
            begin
                src = input_mode ? it.data_pins_in : model_latch;
                if (idx <= LINE_DATA_LAST)
                    lvl = src[idx[2:0]];
                else if (idx == LINE_CTL_INV_LO || idx == LINE_CTL_INV_HI)
                    lvl = ~port_ctl[idx - LINE_CTL_INV_LO];
                else if (idx == LINE_CTL_PL_LO || idx == LINE_CTL_PL_HI)
                    lvl = port_ctl[idx - LINE_CTL_INV_LO];
                else if (idx == LINE_PAPER || idx == LINE_ACK)
                    lvl = it.status_byte[idx - LINE_CTL_INV_LO];
                else if (idx == LINE_SELECT_N || idx == LINE_BUSY_N)
                    lvl = ~it.status_byte[idx - LINE_CTL_INV_LO];
                else if (idx == LINE_ERROR)
                    lvl = it.status_byte[STATUS_ERR_BIT];
                else
                begin
                    bad = 1'b1;
                    unmapped_reads++;
                end
            end
            OP_MASK_HIGH: raise_lines(it.sel_mask);
            OP_MASK_LOW:  lower_lines(it.sel_mask);
            OP_SERVICE:
            begin
                if (irq_flag)
                begin
                    lvl      = 1'b1;
                    irq_flag = 1'b0;
                    irq_serviced++;
                end
            end
            default: ;
        endcase

        r.data_pins_out     = model_latch;
        r.data_drive_enable = ~input_mode;
        r.control_bits_out  = port_ctl;
        r.line_level        = lvl;
        r.line_invalid      = bad;
        r.irq_request       = irq_flag;
        return r;
    endfunction

    function automatic result_t known_result(logic [7:0] dout, logic drv, logic [3:0] ctl,
                                             logic lvl, logic bad, logic irq);
        result_t r;
        r.data_pins_out     = dout;
        r.data_drive_enable = drv;
        r.control_bits_out  = ctl;
        r.line_level        = lvl;
        r.line_invalid      = bad;
        r.irq_request       = irq;
        return r;
    endfunction

    function automatic item_t make_item(logic [2:0] op, logic [4:0] line, logic [16:0] mask,
                                        logic lvl, logic [7:0] pins, logic [7:0] stat);
        item_t it;
        it.operation    = op;
        it.line_index   = line;
        it.sel_mask     = mask;
        it.level        = lvl;
        it.data_pins_in = pins;
        it.status_byte  = stat;
        return it;
    endfunction

    task automatic plan_op(logic [2:0] op, logic [4:0] line, logic [16:0] mask, logic lvl,
                           logic [7:0] pins, logic [7:0] stat, logic fixed, result_t res);
        plan_row_t row;
        row        = '0;
        row.fixed  = fixed;
        row.res    = res;
        row.it     = make_item(op, line, mask, lvl, pins, stat);
        plan_q.push_back(row);
    endtask

    task automatic plan_cfg(logic idx, logic val);
        plan_row_t row;
        row         = '0;
        row.is_cfg  = 1'b1;
        row.cfg_idx = idx;
        row.cfg_val = val;
        plan_q.push_back(row);
    endtask

    function automatic item_t random_item();
        logic [2:0] op;
        logic [4:0] line;
        if ($urandom_range(0, 19) < 18)
            op = 3'($urandom_range(OP_SET_LINE, OP_SERVICE));
        else
            op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        if ($urandom_range(0, 5) == 0)
            line = 5'($urandom_range(NUM_LINES, 31));
        else
            line = 5'($urandom_range(0, NUM_LINES - 1));
        return make_item(op, line, 17'($urandom_range(0, 17'h1FFFF)),
                         1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
    endfunction

    // Present one transaction after a random gap and wait for its acceptance
    task automatic send_item(item_t it, logic fixed, result_t res);
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, it};
        lit_valid     <= fixed;
        lit_res       <= res;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
    endtask

    // Stop sending and wait until every result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (port_results_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write while the port is idle; predictor follows the write
    task automatic write_cfg(logic idx, logic val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_DATA_INPUT_MODE)
            input_mode = val;
        else
        begin
            irq_enable = val;
            if (!val)
                irq_flag = 1'b0;
        end
        cfg_writes++;
    endtask

    // Predict on input acceptance, check on output acceptance
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            acc_item = s_axis_tdata[41:0];
            want_res = predict_port(acc_item);
            if (lit_valid)
                port_results_q.push_back(lit_res);
            else
                port_results_q.push_back(want_res);
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_res = m_axis_tdata;
            if (port_results_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("[%0t] result with nothing pending: %h", $realtime, got_res);
            end
            else
            begin
                want_res = port_results_q.pop_front();
                if (got_res.data_pins_out !== want_res.data_pins_out
                    || got_res.data_drive_enable !== want_res.data_drive_enable
                    || got_res.control_bits_out !== want_res.control_bits_out
                    || got_res.line_level !== want_res.line_level
                    || got_res.line_invalid !== want_res.line_invalid
                    || got_res.irq_request !== want_res.irq_request)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("[%0t] exp data=%h drv=%b ctl=%h lvl=%b inv=%b irq=%b, %s",
                                 $realtime, want_res.data_pins_out,
                                 want_res.data_drive_enable, want_res.control_bits_out,
                                 want_res.line_level, want_res.line_invalid,
                                 want_res.irq_request, "got:");
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("    got data=%h drv=%b ctl=%h lvl=%b inv=%b irq=%b",
                                 got_res.data_pins_out, got_res.data_drive_enable,
                                 got_res.control_bits_out, got_res.line_level,
                                 got_res.line_invalid, got_res.irq_request);
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout after %0d idle cycles", quiet_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // Result receiver with random stalls
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = rx_stalls_on ? $urandom_range(0, 14) : 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    // Main stimulus
    initial
    begin
        plan_row_t row;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = CFG_DATA_INPUT_MODE;
        cfg_data       = 1'b0;
        lit_valid      = 1'b0;
        lit_res        = '0;
        model_latch    = '0;
        port_ctl       = '0;
        ack_seen       = 1'b0;
        irq_flag       = 1'b0;
        input_mode     = 1'b0;
        irq_enable     = 1'b0;
        tx_gaps_on     = 1'b1;
        rx_stalls_on   = 1'b1;
        mismatch_count = 0;
        items_sent     = 0;
        directed_items = 0;
        cfg_writes     = 0;
        irq_serviced   = 0;
        unmapped_reads = 0;
        quiet_cycles   = 0;

        // Directed part: reset values, unmapped lines, full masks, every line kind
        plan_op(OP_GET_LINE, 5'd0, '0, 1'b0, 8'h00, 8'h00, 1'b1,
                known_result(8'h00, 1'b1, 4'h0, 1'b0, 1'b0, 1'b0));
        plan_op(OP_GET_LINE, 5'd31, '0, 1'b0, 8'h00, 8'h00, 1'b1,
                known_result(8'h00, 1'b1, 4'h0, 1'b0, 1'b1, 1'b0));
        plan_op(OP_GET_LINE, 5'(NUM_LINES), '0, 1'b0, 8'h00, 8'h00, 1'b1,
                known_result(8'h00, 1'b1, 4'h0, 1'b0, 1'b1, 1'b0));
        plan_op(OP_MASK_HIGH, 5'd0, 17'h1FFFF, 1'b0, 8'h00, 8'h00, 1'b1,
                known_result(8'hFF, 1'b1, 4'hC, 1'b0, 1'b0, 1'b0));
        plan_op(OP_GET_LINE, LINE_CTL_INV_LO, '0, 1'b0, 8'h00, 8'hFF, 1'b0, '0);
        plan_op(OP_GET_LINE, LINE_CTL_PL_HI, '0, 1'b0, 8'h00, 8'hFF, 1'b0, '0);
        plan_op(OP_MASK_LOW, 5'd0, 17'h1FFFF, 1'b1, 8'hFF, 8'h00, 1'b1,
                known_result(8'h00, 1'b1, 4'h3, 1'b0, 1'b0, 1'b0));
        plan_op(OP_SET_LINE, LINE_DATA_LAST, '0, 1'b1, 8'h00, 8'h00, 1'b0, '0);
        plan_op(OP_SET_LINE, LINE_CTL_INV_HI, '0, 1'b0, 8'h00, 8'h00, 1'b0, '0);
        plan_op(OP_SET_LINE, LINE_CTL_PL_LO, '0, 1'b1, 8'h00, 8'h00, 1'b0, '0);
        // Writes to status lines and unmapped lines are dropped
        plan_op(OP_SET_LINE, LINE_SELECT_N, '0, 1'b1, 8'h00, 8'h00, 1'b0, '0);
        plan_op(OP_SET_LINE, 5'd31, 17'h1FFFF, 1'b1, 8'hFF, 8'h00, 1'b0, '0);
        plan_op(OP_GET_LINE, LINE_SELECT_N, '0, 1'b0, 8'h00, 8'h00, 1'b0, '0);
        plan_op(OP_GET_LINE, LINE_PAPER, '0, 1'b0, 8'h00, 8'h20, 1'b0, '0);
        plan_op(OP_GET_LINE, LINE_ACK, '0, 1'b0, 8'h00, 8'h40, 1'b0, '0);
        plan_op(OP_GET_LINE, LINE_BUSY_N, '0, 1'b0, 8'h00, 8'h80, 1'b0, '0);
        plan_op(OP_GET_LINE, LINE_ERROR, '0, 1'b0, 8'h00, 8'h08, 1'b0, '0);
        // Service with nothing pending, then the unassigned opcodes
        plan_op(OP_SERVICE, 5'd0, '0, 1'b0, 8'h00, 8'h00, 1'b0, '0);
        plan_op(OP_UNUSED_LO, 5'd3, 17'h1FFFF, 1'b1, 8'hFF, 8'hFF, 1'b0, '0);
        plan_op(OP_UNUSED_HI, 5'd0, '0, 1'b0, 8'h00, 8'h00, 1'b0, '0);
        // A read leaves the latch alone and ignores the pins in output mode
        plan_op(OP_GET_LINE, 5'd3, '0, 1'b0, 8'hFF, 8'h00, 1'b0, '0);
        // Input mode reads the pins; interrupt raised on ACK edge and serviced
        plan_cfg(CFG_DATA_INPUT_MODE, 1'b1);
        plan_cfg(CFG_ACK_IRQ_ENABLE, 1'b1);
        plan_op(OP_GET_LINE, 5'd3, '0, 1'b0, 8'h08, 8'h00, 1'b0, '0);
        plan_op(OP_GET_LINE, LINE_DATA_LAST, '0, 1'b0, 8'h7F, 8'h00, 1'b0, '0);
        plan_op(OP_GET_LINE, 5'd0, '0, 1'b0, 8'h00, 8'h40, 1'b0, '0);
        plan_op(OP_SERVICE, 5'd0, '0, 1'b0, 8'h00, 8'h40, 1'b0, '0);
        plan_op(OP_SERVICE, 5'd0, '0, 1'b0, 8'h00, 8'h40, 1'b0, '0);
        plan_op(OP_MASK_HIGH, 5'd0, '0, 1'b0, 8'h00, 8'h00, 1'b0, '0);
        plan_op(OP_MASK_HIGH, 5'd0, '0, 1'b0, 8'h00, 8'h40, 1'b0, '0);
        // Disabling the interrupt drops the pending request
        plan_cfg(CFG_ACK_IRQ_ENABLE, 1'b0);
        plan_op(OP_GET_LINE, LINE_ERROR, '0, 1'b0, 8'h00, 8'h00, 1'b0, '0);
        plan_cfg(CFG_DATA_INPUT_MODE, 1'b0);

        // Reset
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan_q[i])
        begin
            row = plan_q[i];
            if (row.is_cfg)
            begin
                drain();
                write_cfg(row.cfg_idx, row.cfg_val);
            end
            else
            begin
                send_item(row.it, row.fixed, row.res);
                directed_items++;
            end
        end

        // Random phases, each under its own register settings and idle pattern
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            if (p < 4)
            begin
                write_cfg(CFG_DATA_INPUT_MODE, p[0]);
                write_cfg(CFG_ACK_IRQ_ENABLE, p[1]);
            end
            else
            begin
                write_cfg(CFG_ACK_IRQ_ENABLE, 1'($urandom_range(0, 1)));
                write_cfg(CFG_DATA_INPUT_MODE, 1'($urandom_range(0, 1)));
            end
            tx_gaps_on   = (p % 4 != 1) && ($urandom_range(0, 3) != 0);
            rx_stalls_on = (p % 4 != 1) && ($urandom_range(0, 3) != 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_item(random_item(), 1'b0, '0);
        end

        drain();
        if (port_results_q.size() != 0)
            mismatch_count += port_results_q.size();

        $display("Sent %0d transactions (%0d directed) across %0d register writes",
                 items_sent, directed_items, cfg_writes);
        $display("Interrupts serviced: %0d, unmapped line reads: %0d",
                 irq_serviced, unmapped_reads);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
